// File: hw/rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, operation codes and control types of the bitmap
// first-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    localparam int HEAP_ENTRIES = 4096;
    localparam int WORD_BITS    = 64;
    localparam int NWORDS       = HEAP_ENTRIES / WORD_BITS;
    localparam int WIDX_W       = $clog2(NWORDS);
    localparam int BIDX_W       = $clog2(WORD_BITS);

    localparam int OP_W    = 2;
    localparam int COUNT_W = 13;
    localparam int ENTRY_W = 12;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_COUNT = 2'd3;

    localparam logic [COUNT_W-1:0] CFG_RESET = 13'd4096;

    typedef struct packed {
        logic load;
        logic fail;
        logic take;
        logic step;
        logic mark_rd;
        logic mark_wr;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic pre_fail;
        logic hit;
        logic hit_fits;
        logic scan_last;
        logic mark_empty;
        logic mark_last;
    } t_stat;

endpackage

// File: hw/rtl/bffa_in_if.sv
// ----------------------------------------------------------------------------
// bffa_in_if
// Request channel of the allocator.
// ----------------------------------------------------------------------------
interface bffa_in_if;
    logic                            valid;
    logic                            ready;
    logic [bffa_pkg::OP_W-1:0]       op;
    logic [bffa_pkg::COUNT_W-1:0]    entry_count;
    logic [bffa_pkg::ENTRY_W-1:0]    start_entry;

    modport source (output valid, op, entry_count, start_entry, input ready);
    modport sink   (input valid, op, entry_count, start_entry, output ready);
endinterface

// File: hw/rtl/bffa_out_if.sv
// ----------------------------------------------------------------------------
// bffa_out_if
// Result channel of the allocator.
// ----------------------------------------------------------------------------
interface bffa_out_if;
    logic                            valid;
    logic                            ready;
    logic [bffa_pkg::ENTRY_W-1:0]    address;
    logic                            ok;
    logic [bffa_pkg::COUNT_W-1:0]    used_entries;

    modport source (output valid, address, ok, used_entries, input ready);
    modport sink   (input valid, address, ok, used_entries, output ready);
endinterface

// File: hw/rtl/bffa_cfg_if.sv
// ----------------------------------------------------------------------------
// bffa_cfg_if
// Write channel for the heap size register.
// ----------------------------------------------------------------------------
interface bffa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bffa_pkg::COUNT_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/bffa_ram.sv
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/bffa_datapath.sv
// ----------------------------------------------------------------------------
// bffa_datapath
// Bitmap storage, word search logic, range marking and population count.
// ----------------------------------------------------------------------------
module bffa_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bffa_pkg::t_cmd                 i_cmd,
    input  logic [bffa_pkg::OP_W-1:0]      i_op,
    input  logic [bffa_pkg::COUNT_W-1:0]   i_entry_count,
    input  logic [bffa_pkg::ENTRY_W-1:0]   i_start_entry,
    input  logic                           i_cfg_we,
    input  logic [bffa_pkg::COUNT_W-1:0]   i_cfg_data,
    output bffa_pkg::t_stat                o_stat,
    output logic [bffa_pkg::ENTRY_W-1:0]   o_address,
    output logic                           o_ok,
    output logic [bffa_pkg::COUNT_W-1:0]   o_used_entries
);
    localparam int WB = bffa_pkg::WORD_BITS;
    localparam int WW = bffa_pkg::WIDX_W;
    localparam int BW = bffa_pkg::BIDX_W;
    localparam int CW = bffa_pkg::COUNT_W;
    localparam int EW = bffa_pkg::ENTRY_W;
    localparam logic [WB-1:0] ONES = '1;

    logic [CW-1:0]   r_cfg;
    logic [bffa_pkg::OP_W-1:0] r_op;
    logic [CW-1:0]   r_n;
    logic [WW-1:0]   r_w;
    logic [WW:0]     r_run;
    logic [CW-1:0]   r_used;
    logic [EW-1:0]   r_addr;
    logic            r_ok;
    logic [CW-1:0]   r_mstart;
    logic [CW-1:0]   r_mend;
    logic [WW-1:0]   r_mw;
    logic [bffa_pkg::NWORDS-1:0] r_valid;
    logic            r_rvalid;

    logic [CW-1:0]   eff_s;
    logic [WW:0]     n_words;
    logic [WW-1:0]   raddr;
    logic [WB-1:0]   rdata;
    logic [WB-1:0]   word;
    logic [WB-1:0]   wdata;
    logic [WB-1:0]   mask;
    logic [WW:0]     req;
    logic [WW+1:0]   trail;
    logic [WB-1:0]   low_t;
    logic            hit_l;
    logic [WW-1:0]   hit_word_l;
    logic [WB-1:0]   small_m;
    logic [WB-1:0]   fit;
    logic [BW-1:0]   small_b;
    logic            is_small;
    logic [EW-1:0]   hit_addr;
    logic [CW:0]     load_end;
    logic [CW-1:0]   mark_end_in;
    logic [CW-1:0]   word_top;
    logic [BW-1:0]   lo;
    logic            hi_full;

    assign eff_s   = (r_cfg > CW'(bffa_pkg::HEAP_ENTRIES)) ?
                     CW'(bffa_pkg::HEAP_ENTRIES) : r_cfg;
    assign n_words = (WW+1)'((eff_s + CW'(WB - 1)) >> BW);

    assign raddr = i_cmd.mark_rd ? r_mw : (i_cmd.load ? '0 : r_w + WW'(1));
    assign word  = r_rvalid ? rdata : '0;

    // Large requests: whole empty words followed by a word whose low bits fit.
    assign req   = (WW+1)'((r_n - CW'(1)) >> BW);
    assign trail = (WW+2)'(r_n - {req, BW'(0)});
    assign low_t = trail[BW] ? ONES : ~(ONES << trail[BW-1:0]);
    assign hit_l = (word == '0) ? (r_run >= req)
                 : ((r_run == req) && ((word & low_t) == '0));
    assign hit_word_l = r_w - r_run[WW-1:0];

    // Small requests: every offset of the word is tested at once.
    assign small_m  = ~(ONES << r_n[BW-1:0]);
    assign is_small = (r_n < CW'(WB));

    always_comb begin
        for (int b = 0; b < WB; b++) begin
            fit[b] = ((word & (small_m << b)) == '0) &&
                     ((BW+1)'(b) + (BW+1)'(r_n[BW-1:0]) <= (BW+1)'(WB));
        end
        small_b = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (fit[b]) begin
                small_b = BW'(b);
            end
        end
    end

    assign hit_addr = is_small ? {r_w, small_b} : {hit_word_l, BW'(0)};

    assign load_end    = (CW+1)'(i_start_entry) + (CW+1)'(i_entry_count);
    assign mark_end_in = (load_end > (CW+1)'(eff_s)) ? eff_s : load_end[CW-1:0];

    // Bits of the current word that fall inside the range being marked.
    assign word_top = {1'b0, r_mw, BW'(0)} + CW'(WB);
    assign hi_full  = (r_mend >= word_top);
    assign lo       = (r_mw == r_mstart[EW-1:BW]) ? r_mstart[BW-1:0] : '0;
    assign mask     = (ONES << lo) & (hi_full ? ONES : ~(ONES << r_mend[BW-1:0]));
    assign wdata    = word | mask;

    assign o_stat.pre_fail   = (r_n == '0) || (r_n > eff_s);
    assign o_stat.hit        = is_small ? (|fit) : hit_l;
    assign o_stat.hit_fits   = ((CW+1)'(hit_addr) + (CW+1)'(r_n)) <= (CW+1)'(eff_s);
    assign o_stat.scan_last  = (r_op == bffa_pkg::OP_COUNT) ? (r_w == '1)
                             : ((WW+1)'(r_w) + (WW+1)'(1) >= n_words);
    assign o_stat.mark_empty = (r_mstart >= r_mend);
    assign o_stat.mark_last  = (r_mend <= word_top);

    bffa_ram #(
        .WIDTH (WB),
        .DEPTH (bffa_pkg::NWORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mark_wr),
        .i_waddr (r_mw),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= bffa_pkg::CFG_RESET;
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_rvalid <= r_valid[raddr];
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.mark_wr) begin
                r_valid[r_mw] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_n      <= i_entry_count;
            r_w      <= '0;
            r_run    <= '0;
            r_used   <= '0;
            r_addr   <= '0;
            r_ok     <= 1'b1;
            r_mstart <= CW'(i_start_entry);
            r_mend   <= mark_end_in;
            r_mw     <= i_start_entry[EW-1:BW];
        end else begin
            if (i_cmd.step) begin
                r_w    <= r_w + WW'(1);
                r_run  <= (word == '0) ? r_run + (WW+1)'(1) : '0;
                if (r_op == bffa_pkg::OP_COUNT) begin
                    r_used <= r_used + CW'($countones(word));
                end
            end
            if (i_cmd.fail) begin
                r_ok   <= 1'b0;
                r_addr <= '0;
            end
            if (i_cmd.take) begin
                r_addr   <= hit_addr;
                r_mstart <= CW'(hit_addr);
                r_mend   <= CW'(hit_addr) + r_n;
                r_mw     <= hit_addr[EW-1:BW];
            end
            if (i_cmd.mark_wr) begin
                r_mw <= r_mw + WW'(1);
            end
        end
    end

    assign o_address      = r_addr;
    assign o_ok           = r_ok;
    assign o_used_entries = r_used;
endmodule

// File: hw/rtl/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer of the allocator: search, mark, clear and count steps.
// ----------------------------------------------------------------------------
module bffa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [bffa_pkg::OP_W-1:0]   i_op,
    input  logic                        i_out_ready,
    input  bffa_pkg::t_stat             i_stat,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output bffa_pkg::t_cmd              o_cmd
);
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_MARK_RD = 3'd2;
    localparam logic [2:0] ST_MARK_WR = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [bffa_pkg::OP_W-1:0] r_op;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        bffa_pkg::OP_MARK:  n_state = ST_MARK_RD;
                        bffa_pkg::OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_state     = ST_DONE;
                        end
                        default:            n_state = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_op == bffa_pkg::OP_COUNT) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.scan_last) begin
                        n_state = ST_DONE;
                    end
                end else if (i_stat.pre_fail) begin
                    o_cmd.fail = 1'b1;
                    n_state    = ST_DONE;
                end else if (i_stat.hit) begin
                    // A first fit that runs past the heap end is a failure.
                    if (i_stat.hit_fits) begin
                        o_cmd.take = 1'b1;
                        n_state    = ST_MARK_RD;
                    end else begin
                        o_cmd.fail = 1'b1;
                        n_state    = ST_DONE;
                    end
                end else if (i_stat.scan_last) begin
                    o_cmd.fail = 1'b1;
                    n_state    = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_MARK_RD: begin
                if (i_stat.mark_empty) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.mark_rd = 1'b1;
                    n_state       = ST_MARK_WR;
                end
            end
            ST_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                n_state       = i_stat.mark_last ? ST_DONE : ST_MARK_RD;
            end
            ST_DONE: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= bffa_pkg::OP_ALLOC;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_op <= i_op;
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_DONE);
endmodule

// File: hw/rtl/bitmap_first_fit_allocator.sv
// The allocator takes one item at a time and returns one result per item.
// Allocate scans the bitmap RAM one 64-bit word per cycle (for requests under
// 64 entries, all offsets of a word tested together) until a fit or the heap
// end, then marks each word it takes with a read state and a write state; a
// mark-range item also reads and writes each word touched, or goes straight
// to the done state when the range is empty; a count item reads all 64 words,
// and clear goes straight to the done state. The result then waits in the
// done state for its handshake. The single RAM read port limits the scan to
// one word per cycle.
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// Top level: first-fit block allocator over a 4096-entry in-use bitmap.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bffa_in_if.sink     i_in,
    bffa_out_if.source  o_out,
    bffa_cfg_if.sink    i_cfg
);
    bffa_pkg::t_cmd  cmd;
    bffa_pkg::t_stat stat;
    logic            in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    bffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.op),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    bffa_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_in.op),
        .i_entry_count  (i_in.entry_count),
        .i_start_entry  (i_in.start_entry),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_data     (i_cfg.data),
        .o_stat         (stat),
        .o_address      (o_out.address),
        .o_ok           (o_out.ok),
        .o_used_entries (o_out.used_entries)
    );
endmodule

// File: hw/rtl/bffa_checker.sv
// ----------------------------------------------------------------------------
// bffa_checker
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bffa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_ok,
    input logic [bffa_pkg::ENTRY_W-1:0]  i_out_address
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> !i_out_valid)
        else $error("new item offered while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready stayed high after an item was accepted");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ok |-> i_out_address == '0)
        else $error("failed allocation reports a nonzero address");
endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_ok      (o_out.ok),
    .i_out_address (o_out.address)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitmap first-fit allocator: a bit-level
// predictor of the usage map checks every result against random and directed
// allocate, mark, clear and count items under several heap sizes.
// ----------------------------------------------------------------------------
module tb;
    localparam int EW = bffa_pkg::ENTRY_W;
    localparam int CW = bffa_pkg::COUNT_W;
    localparam int OW = bffa_pkg::OP_W;
    localparam int WB = bffa_pkg::WORD_BITS;
    localparam int NW = bffa_pkg::NWORDS;
    localparam int HE = bffa_pkg::HEAP_ENTRIES;

    typedef struct packed {
        logic [EW-1:0] address;
        logic          ok;
        logic [CW-1:0] used_entries;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bffa_in_if  req_ch ();
    bffa_out_if rsp_ch ();
    bffa_cfg_if cfg_ch ();

    bitmap_first_fit_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [WB-1:0] usage_map [NW];
    int unsigned heap_size;
    t_result pending_results [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent = 0;
    int unsigned allocs_ok = 0;
    int unsigned idle_cycles = 0;
    bit stall_enable = 1'b1;

    function automatic logic [WB-1:0] low_mask(int unsigned n);
        if (n == 0) return '0;
        if (n >= WB) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic void fill_range(int unsigned first, int unsigned n, int unsigned lim);
        for (int unsigned e = first; e < lim && e - first < n; e++)
            usage_map[e / WB][e % WB] = 1'b1;
    endfunction

    function automatic t_result predict_item(logic [OW-1:0] op,
                                             int unsigned n, int unsigned first);
        t_result r;
        int unsigned lim;
        int unsigned words;
        int unsigned addr;
        int unsigned req;
        int unsigned trail;
        int unsigned p;
        int unsigned free_words;
        int unsigned used;
        bit found;
        r = '0;
        r.ok = 1'b1;
        lim = (heap_size > HE) ? HE : heap_size;
        case (op)
            bffa_pkg::OP_ALLOC: begin
                words = (lim + WB - 1) / WB;
                found = 1'b0;
                addr = 0;
                if (n != 0 && n <= lim) begin
                    if (n < WB) begin
                        for (int unsigned w = 0; w < words && !found; w++)
                            for (int unsigned b = 0; b + n <= WB && !found; b++)
                                if ((usage_map[w] & (low_mask(n) << b)) == '0) begin
                                    found = 1'b1;
                                    addr = w * WB + b;
                                end
                    end else begin
                        req = (n + WB - 1) / WB - 1;
                        trail = n - req * WB;
                        p = 0;
                        while (!found && p + req < words) begin
                            free_words = 0;
                            while (p + free_words < words && usage_map[p + free_words] == '0)
                                free_words++;
                            if (free_words > req || (free_words == req &&
                                (usage_map[p + req] & low_mask(trail)) == '0)) begin
                                found = 1'b1;
                                addr = p * WB;
                            end else begin
                                p += (free_words > 0) ? free_words : 1;
                            end
                        end
                    end
                end
                if (found && addr + n <= lim) begin
                    fill_range(addr, n, lim);
                    r.address = addr[EW-1:0];
                end else begin
                    r.ok = 1'b0;
                end
            end
            bffa_pkg::OP_MARK: fill_range(first, n, lim);
            bffa_pkg::OP_CLEAR: foreach (usage_map[w]) usage_map[w] = '0;
            default: begin
                used = 0;
                foreach (usage_map[w]) used += $countones(usage_map[w]);
                r.used_entries = used[CW-1:0];
            end
        endcase
        return r;
    endfunction

    // Valid stays high after an accept when the next item follows at once.
    task automatic send_request(logic [OW-1:0] op, int unsigned n, int unsigned first);
        int unsigned gap;
        gap = stall_enable ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.op <= op;
        req_ch.entry_count <= n[CW-1:0];
        req_ch.start_entry <= first[EW-1:0];
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(predict_item(op, n, first));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        if (req_ch.valid) req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_heap_size(int unsigned value);
        drain_results();
        cfg_ch.data <= value[CW-1:0];
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        heap_size = value & 13'h1FFF;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random backpressure, checks against the oldest prediction.
    initial begin
        int unsigned hold;
        t_result want;
        t_result got;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = stall_enable ? $urandom_range(0, 12) : 0;
            if (hold != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            got = '{rsp_ch.address, rsp_ch.ok, rsp_ch.used_entries};
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item: addr %0d ok %0d used %0d",
                             got.address, got.ok, got.used_entries);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch on result %0d: expected addr %0d ok %0d used %0d,",
                                 results_seen, want.address, want.ok, want.used_entries);
                        $display("    got addr %0d ok %0d used %0d",
                                 got.address, got.ok, got.used_entries);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any handshake on the request, result or config channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        send_request(bffa_pkg::OP_COUNT, 0, 0);
        send_request(bffa_pkg::OP_ALLOC, 0, 0);
        send_request(bffa_pkg::OP_ALLOC, 8191, 0);
        send_request(bffa_pkg::OP_ALLOC, 4097, 0);
        send_request(bffa_pkg::OP_ALLOC, 1, 0);
        send_request(bffa_pkg::OP_ALLOC, 63, 0);
        send_request(bffa_pkg::OP_ALLOC, 64, 0);
        send_request(bffa_pkg::OP_ALLOC, 65, 0);
        send_request(bffa_pkg::OP_MARK, 0, 4095);
        send_request(bffa_pkg::OP_MARK, 8191, 4000);
        send_request(bffa_pkg::OP_MARK, 3, 4095);
        send_request(bffa_pkg::OP_COUNT, 0, 0);
        send_request(bffa_pkg::OP_CLEAR, 8191, 4095);
        send_request(bffa_pkg::OP_ALLOC, 4096, 0);
        send_request(bffa_pkg::OP_COUNT, 0, 0);
        send_request(bffa_pkg::OP_ALLOC, 1, 0);
        send_request(bffa_pkg::OP_CLEAR, 0, 0);
    endtask

    task automatic test_shrunken_heap();
        write_heap_size(100);
        send_request(bffa_pkg::OP_MARK, 50, 90);
        send_request(bffa_pkg::OP_ALLOC, 36, 0);
        send_request(bffa_pkg::OP_ALLOC, 100, 0);
        send_request(bffa_pkg::OP_ALLOC, 54, 0);
        send_request(bffa_pkg::OP_COUNT, 0, 0);
        write_heap_size(64);
        send_request(bffa_pkg::OP_COUNT, 0, 0);
        send_request(bffa_pkg::OP_ALLOC, 64, 0);
        send_request(bffa_pkg::OP_CLEAR, 0, 0);
        send_request(bffa_pkg::OP_ALLOC, 64, 0);
        send_request(bffa_pkg::OP_ALLOC, 1, 0);
        write_heap_size(8191);
        send_request(bffa_pkg::OP_ALLOC, 4096, 0);
        send_request(bffa_pkg::OP_COUNT, 0, 0);
    endtask

    task automatic random_phase(int unsigned items);
        int unsigned kind;
        int unsigned n;
        for (int unsigned i = 0; i < items; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                case ($urandom_range(0, 3))
                    0: n = $urandom_range(1, 63);
                    1: n = $urandom_range(1, 8);
                    2: n = $urandom_range(64, 300);
                    default: n = $urandom_range(0, 8191);
                endcase
                send_request(bffa_pkg::OP_ALLOC, n, 0);
            end else if (kind < 80) begin
                send_request(bffa_pkg::OP_MARK,
                             $urandom_range(0, 8191) >> $urandom_range(0, 12),
                             $urandom_range(0, 4095));
            end else if (kind < 86) begin
                send_request(bffa_pkg::OP_CLEAR, $urandom_range(0, 8191),
                             $urandom_range(0, 4095));
            end else begin
                send_request(bffa_pkg::OP_COUNT, $urandom_range(0, 8191),
                             $urandom_range(0, 4095));
            end
            if (pending_results.size() != 0 && pending_results[$].ok && kind < 60)
                allocs_ok++;
        end
    endtask

    task automatic test_random_sizes();
        random_phase(300);
        write_heap_size($urandom_range(64, 4096));
        random_phase(300);
        write_heap_size(4096);
        // Run one stretch with no idling on either side.
        stall_enable = 1'b0;
        random_phase(200);
        stall_enable = 1'b1;
        drain_results();
        write_heap_size(65);
        random_phase(200);
        write_heap_size($urandom_range(4097, 8191));
        random_phase(270);
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.op = bffa_pkg::OP_ALLOC;
        req_ch.entry_count = '0;
        req_ch.start_entry = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = bffa_pkg::CFG_RESET;
        heap_size = HE;
        foreach (usage_map[w]) usage_map[w] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_extremes();
        test_shrunken_heap();
        test_random_sizes();
        drain_results();
        $display("Covered %0d items with %0d results and %0d successful random allocations,",
                 items_sent, results_seen, allocs_ok);
        $display("across heap sizes from 64 up to beyond the full heap.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/bffa_pkg.sv
hw/rtl/bffa_in_if.sv
hw/rtl/bffa_out_if.sv
hw/rtl/bffa_cfg_if.sv
hw/rtl/bffa_ram.sv
hw/rtl/bffa_datapath.sv
hw/rtl/bffa_ctrl.sv
hw/rtl/bitmap_first_fit_allocator.sv
hw/rtl/bffa_checker.sv
dv/tb.sv
